/* sv/vec3_point_transform_project_top_macros.svh */
// Assertion macros for the point transform RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef VEC3_POINT_TRANSFORM_PROJECT_TOP_MACROS_SVH
`define VEC3_POINT_TRANSFORM_PROJECT_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define VPT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define VPT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define VPT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define VPT_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* sv/vpt_pkg.sv */
// Types and constants of the point transform and projection block.
// No dependencies; every module and interface file imports it.
package vpt_pkg;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned NUM_COLS = 4;
  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned ACC_W    = 66;
  localparam int unsigned MAX_FRAC = 24;
  localparam int unsigned QUO_W    = 34;
  localparam int unsigned REM_W    = ACC_W + QUO_W;
  localparam int unsigned CFG_W    = 64;
  localparam int unsigned NUM_REGS = 8;

  localparam logic [COORD_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] NEG_LIMIT = 32'h8000_0000;

  typedef enum logic [2:0] {
    REG_ROW0_COLS01,
    REG_ROW0_COLS23,
    REG_ROW1_COLS01,
    REG_ROW1_COLS23,
    REG_ROW2_COLS01,
    REG_ROW2_COLS23,
    REG_ROW3_COLS01,
    REG_ROW3_COLS23
  } cfg_reg_e;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [NUM_REGS-1:0][CFG_W-1:0] cfg_bank_t;
  typedef logic [NUM_COLS-1:0][NUM_COLS-1:0][COORD_W-1:0] matrix_t;
  typedef logic [NUM_COLS-1:0][ACC_W-1:0] acc_vec_t;

  // Identity matrix after reset.
  localparam cfg_bank_t CFG_RESET = {
    64'h0001_0000_0000_0000,  // row 3 cols 2,3
    64'h0000_0000_0000_0000,  // row 3 cols 0,1
    64'h0000_0000_0001_0000,  // row 2 cols 2,3
    64'h0000_0000_0000_0000,  // row 2 cols 0,1
    64'h0000_0000_0000_0000,  // row 1 cols 2,3
    64'h0001_0000_0000_0000,  // row 1 cols 0,1
    64'h0000_0000_0000_0000,  // row 0 cols 2,3
    64'h0000_0000_0001_0000   // row 0 cols 0,1
  };

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [REM_W-1:0] den;
    logic [QUO_W-1:0] quo;
    logic             neg;
  } div_lane_t;

  typedef struct packed {
    logic                            valid;
    logic                            w_zero;
    logic [NUM_LANES-1:0][$bits(div_lane_t)-1:0] lane;
  } div_stage_t;

endpackage

/* sv/vpt_if.sv */
// Handshake channels for input points and projected results.
// Depends on vpt_pkg for the coordinate type.
interface vpt_in_if;
  import vpt_pkg::*;
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;
  modport source (output valid, output point_x, output point_y, output point_z,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input point_z,
                output ready);
endinterface

interface vpt_out_if;
  import vpt_pkg::*;
  logic   valid;
  logic   ready;
  coord_t proj_x;
  coord_t proj_y;
  coord_t proj_z;
  logic   w_zero;
  logic   saturated;
  modport source (output valid, output proj_x, output proj_y, output proj_z,
                  output w_zero, output saturated, input ready);
  modport sink (input valid, input proj_x, input proj_y, input proj_z,
                input w_zero, input saturated, output ready);
endinterface

/* sv/vpt_transform.sv */
// Matrix stage: input register, twelve products, four column sums.
// Depends on vpt_pkg.
module vpt_transform #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  vpt_pkg::coord_t   x,
  input  vpt_pkg::coord_t   y,
  input  vpt_pkg::coord_t   z,
  input  vpt_pkg::matrix_t  mat,
  output logic              out_valid,
  output vpt_pkg::acc_vec_t acc
);
  import vpt_pkg::*;

  logic                      va;
  logic                      vb;
  coord_t                    pa [NUM_LANES];
  logic signed [2*COORD_W-1:0] prod [NUM_LANES][NUM_COLS];

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va        <= in_valid;
      vb        <= va;
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa[0] <= x;
      pa[1] <= y;
      pa[2] <= z;
      for (int r = 0; r < NUM_LANES; r++) begin
        for (int c = 0; c < NUM_COLS; c++) begin
          prod[r][c] <= pa[r] * $signed(mat[r][c]);
        end
      end
      // The translation row is shifted into the fraction scale of the products.
      for (int c = 0; c < NUM_COLS; c++) begin
        acc[c] <= ACC_W'(prod[0][c]) + ACC_W'(prod[1][c]) + ACC_W'(prod[2][c])
                + (ACC_W'($signed(mat[NUM_COLS-1][c])) <<< FRAC_BITS);
      end
    end
  end

endmodule

/* sv/vpt_div_step.sv */
// One restoring division step for all three lanes, registered.
// Depends on vpt_pkg.
module vpt_div_step #(
  parameter int unsigned BIT = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  vpt_pkg::div_stage_t d_in,
  output vpt_pkg::div_stage_t d_out
);
  import vpt_pkg::*;

  div_stage_t d_next;
  div_lane_t  li [NUM_LANES];
  div_lane_t  lo [NUM_LANES];
  logic [REM_W-1:0] sub [NUM_LANES];

  always_comb begin
    d_next = d_in;
    for (int l = 0; l < NUM_LANES; l++) begin
      li[l]  = d_in.lane[l];
      lo[l]  = li[l];
      sub[l] = li[l].den << BIT;
      if (li[l].rem >= sub[l]) begin
        lo[l].rem      = li[l].rem - sub[l];
        lo[l].quo[BIT] = 1'b1;
      end
      d_next.lane[l] = lo[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (en) begin
      d_out <= d_next;
    end
  end

endmodule

/* sv/vpt_divider.sv */
// Perspective divide: operand set-up, pipelined restoring division, rounding
// and saturation into the output register. Depends on vpt_pkg, vpt_div_step.
`include "vec3_point_transform_project_top_macros.svh"
module vpt_divider #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  vpt_pkg::acc_vec_t acc,
  output logic              o_valid,
  output vpt_pkg::coord_t   o_x,
  output vpt_pkg::coord_t   o_y,
  output vpt_pkg::coord_t   o_z,
  output logic              o_wz,
  output logic              o_sat
);
  import vpt_pkg::*;

  div_stage_t       st [QUO_W+1];
  div_stage_t       s0_next;
  div_lane_t        pl [NUM_LANES];
  logic [ACC_W-1:0] nmag [NUM_LANES];
  logic [ACC_W-1:0] dmag;
  logic             dn;

  div_lane_t        fl [NUM_LANES];
  logic [QUO_W-1:0] limit [NUM_LANES];
  logic [COORD_W-1:0] mag [NUM_LANES];
  logic [COORD_W-1:0] res [NUM_LANES];
  logic [NUM_LANES-1:0] ov;

  // Rounding: quotient of (2|n| << F) + |d| by 2|d| is |n|/|d| to nearest,
  // ties away from zero.
  always_comb begin
    dn   = acc[NUM_COLS-1][ACC_W-1];
    dmag = dn ? (~acc[NUM_COLS-1] + 1'b1) : acc[NUM_COLS-1];
    s0_next.valid  = in_valid;
    s0_next.w_zero = (acc[NUM_COLS-1] == '0);
    for (int l = 0; l < NUM_LANES; l++) begin
      nmag[l]    = acc[l][ACC_W-1] ? (~acc[l] + 1'b1) : acc[l];
      pl[l].rem  = (REM_W'(nmag[l]) << (FRAC_BITS + 1)) + REM_W'(dmag);
      pl[l].den  = REM_W'(dmag) << 1;
      pl[l].quo  = '0;
      pl[l].neg  = acc[l][ACC_W-1] ^ dn;
      s0_next.lane[l] = pl[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].valid <= 1'b0;
    end else if (en) begin
      st[0] <= s0_next;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    vpt_div_step #(.BIT(QUO_W - 1 - k)) u_step (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .d_in  (st[k]),
      .d_out (st[k+1])
    );
  end

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      fl[l]    = st[QUO_W].lane[l];
      limit[l] = fl[l].neg ? QUO_W'(NEG_LIMIT) : QUO_W'(POS_LIMIT);
      ov[l]    = fl[l].quo > limit[l];
      mag[l]   = ov[l] ? limit[l][COORD_W-1:0] : fl[l].quo[COORD_W-1:0];
      res[l]   = fl[l].neg ? (~mag[l] + 1'b1) : mag[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= st[QUO_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_wz <= st[QUO_W].w_zero;
      if (st[QUO_W].w_zero) begin
        o_x   <= '0;
        o_y   <= '0;
        o_z   <= '0;
        o_sat <= 1'b0;
      end else begin
        o_x   <= res[0];
        o_y   <= res[1];
        o_z   <= res[2];
        o_sat <= |ov;
      end
    end
  end

  `VPT_ASSERT_IMP(a_wzero_clear, clk, rst, o_valid && o_wz, !o_sat && o_x == 0 && o_y == 0 && o_z == 0)
  `VPT_ASSERT_IMP(a_sat_clamped, clk, rst, o_valid && o_sat, o_x == POS_LIMIT || o_x == NEG_LIMIT || o_y == POS_LIMIT || o_y == NEG_LIMIT || o_z == POS_LIMIT || o_z == NEG_LIMIT)
  `VPT_ASSERT_NXT(a_stall_hold, clk, rst, o_valid && !en, o_valid && $stable(o_x) && $stable(o_sat))

endmodule

/* sv/vec3_point_transform_project_top.sv */
// Top level of the homogeneous point transform with perspective divide.
// Depends on vpt_pkg, vpt_if, vpt_transform, vpt_divider.
//
//  channel   direction  payload
//  pt_in     sink       point_x, point_y, point_z
//  pt_out    source     proj_x, proj_y, proj_z, w_zero, saturated
//  cfg_*     write      cfg_index selects one of eight matrix registers
//
// One item enters per cycle unless the output stalls; each one passes through
// three matrix stages, one divide set-up stage, 34 restoring division steps
// and the output register. The division pipeline sets the latency.
// Reset clears the valid bits and loads the identity matrix.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
module vec3_point_transform_project_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  vpt_in_if.sink                      pt_in,
  vpt_out_if.source                   pt_out,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [vpt_pkg::CFG_W-1:0]   cfg_data
);
  import vpt_pkg::*;

  cfg_bank_t cfg_regs;
  matrix_t   mat;
  acc_vec_t  acc;
  logic      acc_valid;
  logic      en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= CFG_RESET;
    end else if (cfg_we) begin
      cfg_regs[cfg_index] <= cfg_data;
    end
  end

  // Even columns sit in the low half of each register.
  for (genvar r = 0; r < NUM_COLS; r++) begin : g_row
    for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
      assign mat[r][c] = cfg_regs[r*2 + c/2][(c%2)*COORD_W +: COORD_W];
    end
  end

  assign en          = !pt_out.valid || pt_out.ready;
  assign pt_in.ready = en;

  vpt_transform #(.FRAC_BITS(FRAC_BITS)) u_transform (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pt_in.valid),
    .x         (pt_in.point_x),
    .y         (pt_in.point_y),
    .z         (pt_in.point_z),
    .mat       (mat),
    .out_valid (acc_valid),
    .acc       (acc)
  );

  vpt_divider #(.FRAC_BITS(FRAC_BITS)) u_divider (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (acc_valid),
    .acc      (acc),
    .o_valid  (pt_out.valid),
    .o_x      (pt_out.proj_x),
    .o_y      (pt_out.proj_y),
    .o_z      (pt_out.proj_z),
    .o_wz     (pt_out.w_zero),
    .o_sat    (pt_out.saturated)
  );

endmodule
